FILE: rtl/srw_pkg.sv
// Package with the shared constants, codes and control types of the reorder window.
`default_nettype none
package srw_pkg;

  localparam int WINDOW     = 32;
  localparam int SLOT_W     = $clog2(WINDOW);
  localparam int SEQ_W      = 32;
  localparam int HND_W      = 16;
  localparam int LEN_W      = 16;
  localparam int TICK_W     = 16;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int ENTRY_W    = HND_W + LEN_W + 1;

  typedef enum logic [MODE_W-1:0] {
    MODE_PKT   = 2'd0,
    MODE_TICK  = 2'd1,
    MODE_FLUSH = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZFILL   = 1'b1;

  localparam logic [TICK_W-1:0] TIMEOUT_RST = 16'd100;
  localparam logic              ZFILL_RST   = 1'b1;
  localparam logic [TICK_W-1:0] TICK_MAX    = '1;

  typedef struct packed {
    logic cap;
    logic pkt_emit;
    logic pkt_store;
    logic tick;
    logic rd;
    logic load;
    logic flush;
  } srw_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  started;
    logic  pkt_hit;
    logic  tick_fire;
    logic  occ_head;
    logic  occ_any;
    logic  out_free;
  } srw_sts_t;

endpackage
`default_nettype wire

FILE: rtl/srw_ifs.sv
// Channel interfaces for the input, result and configuration words.
`default_nettype none
interface srw_in_if
  import srw_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [SEQ_W-1:0]   seq_in;
  logic [HND_W-1:0]   handle_in;
  logic [LEN_W-1:0]   length_in;
  logic               incomplete_in;

  modport source (output valid, mode, seq_in, handle_in, length_in, incomplete_in,
                  input ready);
  modport sink (input valid, mode, seq_in, handle_in, length_in, incomplete_in,
                output ready);
endinterface

interface srw_out_if
  import srw_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [SEQ_W-1:0]  seq_out;
  logic [HND_W-1:0]  handle_out;
  logic [LEN_W-1:0]  length_out;
  logic              incomplete_out;
  logic              zero_filled;
  logic              last;

  modport source (output valid, seq_out, handle_out, length_out, incomplete_out,
                  zero_filled, last, input ready);
  modport sink (input valid, seq_out, handle_out, length_out, incomplete_out,
                zero_filled, last, output ready);
endinterface

interface srw_cfg_if
  import srw_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/sequence_reorder_window.sv
// Top level of the sequence reorder window for packet descriptor words.
//
//   Channel  Direction  Handshake        Word
//   in_ch    sink       valid / ready    mode, seq_in, handle_in, length_in, incomplete_in
//   out_ch   source     valid / ready    seq_out, handle_out, length_out, incomplete_out,
//                                        zero_filled, last
//   cfg_ch   sink       valid / ready    index, data (0 timeout_ticks, 1 zero_fill_enable)
//
// A buffered, dropped or ignored word and a tick that does not time out return to idle
// after the decide step. A released packet or timeout goes on to the check step, and each
// drained or flushed slot passes through check, slot memory read and result load.
// Reset is synchronous and active low; the slot memory is not cleared.
// A stalled result register holds the sequencer, but a new word is taken while a
// finished result still waits. cfg_ch is always ready.
`default_nettype none
module sequence_reorder_window
  import srw_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  srw_in_if.sink   in_ch,
  srw_out_if.source out_ch,
  srw_cfg_if.sink  cfg_ch
);

  srw_cmd_t cmd;
  srw_sts_t sts;
  logic     in_ready;

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  srw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  srw_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .mode           (in_ch.mode),
    .seq_in         (in_ch.seq_in),
    .handle_in      (in_ch.handle_in),
    .length_in      (in_ch.length_in),
    .incomplete_in  (in_ch.incomplete_in),
    .cfg_valid      (cfg_ch.valid),
    .cfg_index      (cfg_ch.index),
    .cfg_data       (cfg_ch.data),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .seq_out        (out_ch.seq_out),
    .handle_out     (out_ch.handle_out),
    .length_out     (out_ch.length_out),
    .incomplete_out (out_ch.incomplete_out),
    .zero_filled    (out_ch.zero_filled),
    .last           (out_ch.last)
  );

endmodule
`default_nettype wire

FILE: rtl/srw_ctrl.sv
// Controller state machine that sequences decide, drain and flush steps.
`default_nettype none
module srw_ctrl
  import srw_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire srw_sts_t sts,
  output srw_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_CHECK,
    S_READ,
    S_LOAD
  } state_t;

  state_t state_r, state_nxt;
  logic   flush_r, flush_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    cmd.flush = flush_r;
    state_nxt = state_r;
    flush_nxt = flush_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.out_free) begin
          unique case (sts.mode)
            MODE_PKT: begin
              if (sts.pkt_hit) begin
                cmd.pkt_emit = 1'b1;
                flush_nxt    = 1'b0;
                state_nxt    = S_CHECK;
              end else begin
                cmd.pkt_store = 1'b1;
                state_nxt     = S_IDLE;
              end
            end
            MODE_TICK: begin
              if (sts.started) begin
                cmd.tick  = 1'b1;
                flush_nxt = 1'b0;
                state_nxt = sts.tick_fire ? S_CHECK : S_IDLE;
              end else begin
                state_nxt = S_IDLE;
              end
            end
            MODE_FLUSH: begin
              flush_nxt = 1'b1;
              state_nxt = S_CHECK;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_CHECK: begin
        if (flush_r ? sts.occ_any : sts.occ_head) begin
          state_nxt = S_READ;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (sts.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      flush_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      flush_r <= flush_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/srw_dp.sv
// Datapath with window state, slot memory, configuration and result register.
`default_nettype none
module srw_dp
  import srw_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire srw_cmd_t              cmd,
  output srw_sts_t                   sts,
  input  wire logic [MODE_W-1:0]     mode,
  input  wire logic [SEQ_W-1:0]      seq_in,
  input  wire logic [HND_W-1:0]      handle_in,
  input  wire logic [LEN_W-1:0]      length_in,
  input  wire logic                  incomplete_in,
  input  wire logic                  cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [SEQ_W-1:0]           seq_out,
  output logic [HND_W-1:0]           handle_out,
  output logic [LEN_W-1:0]           length_out,
  output logic                       incomplete_out,
  output logic                       zero_filled,
  output logic                       last
);

  logic [TICK_W-1:0]  timeout_r;
  logic               zfill_r;
  mode_t              mode_r;
  logic [SEQ_W-1:0]   seq_r;
  logic [HND_W-1:0]   hnd_r;
  logic [LEN_W-1:0]   len_r;
  logic               inc_r;

  logic               started_r, started_nxt;
  logic [SEQ_W-1:0]   exp_r, exp_nxt;
  logic [SLOT_W-1:0]  head_r, head_nxt;
  logic [WINDOW-1:0]  occ_r, occ_nxt;
  logic [TICK_W-1:0]  idle_r, idle_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic [ENTRY_W-1:0] slot_mem [WINDOW];
  logic [ENTRY_W-1:0] rd_data_r;
  logic [SLOT_W-1:0]  sel_idx_r;
  logic [SLOT_W-1:0]  sel_dist_r;

  logic [SEQ_W-1:0]   seq_out_r, seq_out_nxt;
  logic [HND_W-1:0]   hnd_out_r, hnd_out_nxt;
  logic [LEN_W-1:0]   len_out_r, len_out_nxt;
  logic               inc_out_r, inc_out_nxt;
  logic               zf_out_r, zf_out_nxt;
  logic               last_out_r, last_out_nxt;
  logic               out_ld;

  logic [SEQ_W-1:0]    exp_eff;
  logic [SEQ_W-1:0]    delta;
  logic [SLOT_W-1:0]   pkt_idx;
  logic                pkt_hit;
  logic                store_ok;
  logic [SLOT_W-1:0]   head_p1;
  logic [SLOT_W-1:0]   sel_p1;
  logic [TICK_W-1:0]   idle_inc;
  logic                tick_fire;
  logic [2*WINDOW-1:0] occ_dbl;
  logic [WINDOW-1:0]   occ_rot;
  logic [WINDOW-1:0]   occ_low;
  logic [SLOT_W-1:0]   ff_dist;
  logic [SLOT_W-1:0]   rd_idx;
  logic [WINDOW-1:0]   occ_clr;
  logic                out_free;

  assign exp_eff   = started_r ? exp_r : seq_r;
  assign delta     = seq_r - exp_eff;
  assign pkt_idx   = head_r + delta[SLOT_W-1:0];
  assign pkt_hit   = (delta == '0);
  assign store_ok  = (delta[SEQ_W-1:SLOT_W] == '0) && !pkt_hit && !occ_r[pkt_idx];
  assign head_p1   = head_r + 1'b1;
  assign sel_p1    = sel_idx_r + 1'b1;
  assign idle_inc  = (idle_r == TICK_MAX) ? idle_r : idle_r + 1'b1;
  assign tick_fire = (idle_inc >= timeout_r);
  assign occ_dbl   = {occ_r, occ_r} >> head_r;
  assign occ_rot   = occ_dbl[WINDOW-1:0];
  assign occ_low   = occ_rot & (~occ_rot + 1'b1);
  assign rd_idx    = cmd.flush ? head_r + ff_dist : head_r;
  assign occ_clr   = occ_r & ~(WINDOW'(1) << sel_idx_r);
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    ff_dist = '0;
    for (int i = 0; i < WINDOW; i++) begin
      if (occ_low[i]) begin
        ff_dist = ff_dist | SLOT_W'(i);
      end
    end
  end

  always_comb begin
    sts.mode      = mode_r;
    sts.started   = started_r;
    sts.pkt_hit   = pkt_hit;
    sts.tick_fire = tick_fire;
    sts.occ_head  = occ_r[head_r];
    sts.occ_any   = (occ_r != '0);
    sts.out_free  = out_free;
  end

  always_comb begin
    started_nxt   = started_r;
    exp_nxt       = exp_r;
    head_nxt      = head_r;
    occ_nxt       = occ_r;
    idle_nxt      = idle_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_ld        = 1'b0;
    seq_out_nxt   = exp_r;
    hnd_out_nxt   = '0;
    len_out_nxt   = '0;
    inc_out_nxt   = 1'b1;
    zf_out_nxt    = 1'b1;
    last_out_nxt  = !occ_r[head_p1];

    if (cmd.pkt_emit) begin
      started_nxt = 1'b1;
      exp_nxt     = seq_r + 1'b1;
      head_nxt    = head_p1;
      idle_nxt    = '0;
      out_ld      = 1'b1;
      seq_out_nxt = seq_r;
      hnd_out_nxt = hnd_r;
      len_out_nxt = len_r;
      inc_out_nxt = inc_r;
      zf_out_nxt  = 1'b0;
    end

    if (cmd.pkt_store && store_ok) begin
      occ_nxt = occ_r | (WINDOW'(1) << pkt_idx);
    end

    if (cmd.tick) begin
      if (tick_fire) begin
        exp_nxt  = exp_r + 1'b1;
        head_nxt = head_p1;
        idle_nxt = '0;
        out_ld   = zfill_r;
      end else begin
        idle_nxt = idle_inc;
      end
    end

    if (cmd.load) begin
      occ_nxt     = occ_clr;
      out_ld      = 1'b1;
      hnd_out_nxt = rd_data_r[HND_W-1:0];
      len_out_nxt = rd_data_r[HND_W +: LEN_W];
      inc_out_nxt = rd_data_r[ENTRY_W-1];
      zf_out_nxt  = 1'b0;
      if (cmd.flush) begin
        seq_out_nxt  = exp_r + SEQ_W'(sel_dist_r);
        last_out_nxt = (occ_clr == '0);
      end else begin
        seq_out_nxt  = exp_r;
        last_out_nxt = !occ_r[sel_p1];
        exp_nxt      = exp_r + 1'b1;
        head_nxt     = head_p1;
        idle_nxt     = '0;
      end
    end

    if (out_ld) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= TIMEOUT_RST;
      zfill_r     <= ZFILL_RST;
      started_r   <= 1'b0;
      exp_r       <= '0;
      head_r      <= '0;
      occ_r       <= '0;
      idle_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_TIMEOUT: timeout_r <= cfg_data[TICK_W-1:0];
          CFG_ZFILL:   zfill_r   <= cfg_data[0];
          default:     ;
        endcase
      end
      started_r   <= started_nxt;
      exp_r       <= exp_nxt;
      head_r      <= head_nxt;
      occ_r       <= occ_nxt;
      idle_r      <= idle_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      mode_r <= mode_t'(mode);
      seq_r  <= seq_in;
      hnd_r  <= handle_in;
      len_r  <= length_in;
      inc_r  <= incomplete_in;
    end
    if (cmd.rd) begin
      sel_idx_r  <= rd_idx;
      sel_dist_r <= cmd.flush ? ff_dist : '0;
    end
    if (out_ld) begin
      seq_out_r  <= seq_out_nxt;
      hnd_out_r  <= hnd_out_nxt;
      len_out_r  <= len_out_nxt;
      inc_out_r  <= inc_out_nxt;
      zf_out_r   <= zf_out_nxt;
      last_out_r <= last_out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pkt_store && store_ok) begin
      slot_mem[pkt_idx] <= {inc_r, len_r, hnd_r};
    end
    if (cmd.rd) begin
      rd_data_r <= slot_mem[rd_idx];
    end
  end

  assign out_valid      = out_valid_r;
  assign seq_out        = seq_out_r;
  assign handle_out     = hnd_out_r;
  assign length_out     = len_out_r;
  assign incomplete_out = inc_out_r;
  assign zero_filled    = zf_out_r;
  assign last           = last_out_r;

endmodule
`default_nettype wire
